>>> design/bfi_pkg.sv
// Shared types and constants of the Bloom filter insert and query core.
package bfi_pkg;

    localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
    // The FNV prime is 2^40 + 0x1b3, so the product splits into a shift and a narrow multiply.
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;
    localparam int          FNV_PRIME_SH = 40;
    localparam int          BITS_W       = 17;
    localparam int          PROBES_W     = 6;
    localparam int          CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_COUNT = 2'd1;

    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic load_div;
        logic div_step;
        logic mem_op;
        logic chk;
        logic next_probe;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic m_zero;
        logic div_done;
        logic probe_last;
        logic is_query;
    } t_sts;

    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << FNV_PRIME_SH) + x * {55'd0, FNV_PRIME_LO};
    endfunction

endpackage

>>> design/bloom_filter_fnv_insert_query_core.sv
// Top level of the Bloom filter insert and query core with FNV-1a hashing.
//
// Channel   Direction  Handshake                      Payload
// item      in         i_start & !o_busy              i_mode, i_key_byte, i_has_byte, i_last
// result    out        o_result_valid (one cycle)     o_was_query, o_may_contain
// config    in         i_cfg_valid & o_cfg_ready      i_cfg_index, i_cfg_data
//
// An item without its last mark is taken in idle; on a key's last beat the core runs,
// per probe (k the probe count), a load, a serial remainder, a bit store access and, for
// queries, a check. With an empty filter the last beat goes straight to the finish state.
// After reset a clearing pass over all MAX_FILTER_BITS bits runs with o_busy high.
// The receiver cannot stall; each result is shown for one cycle.
module bloom_filter_fnv_insert_query_core
    import bfi_pkg::*;
#(
    parameter int MAX_FILTER_BITS = 65536,
    parameter int MAX_PROBES      = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic                 i_mode,
    input  logic [7:0]           i_key_byte,
    input  logic                 i_has_byte,
    input  logic                 i_last,
    output logic                 o_result_valid,
    output logic                 o_was_query,
    output logic                 o_may_contain,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BITS_W-1:0]    i_cfg_data
);
    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    bfi_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_last (i_last),
        .i_sts  (sts),
        .o_cmd  (cmd),
        .o_busy (o_busy)
    );

    bfi_dp #(.MAX_FILTER_BITS(MAX_FILTER_BITS), .MAX_PROBES(MAX_PROBES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_mode        (i_mode),
        .i_key_byte    (i_key_byte),
        .i_has_byte    (i_has_byte),
        .i_last        (i_last),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_result_valid(o_result_valid),
        .o_was_query   (o_was_query),
        .o_may_contain (o_may_contain)
    );
endmodule

>>> design/bfi_ram.sv
// Generic single-port-write RAM with one registered read port.
module bfi_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/bfi_ctrl.sv
// Controller state machine sequencing the clearing pass, hashing, probe remainders and bit store access.
module bfi_ctrl
    import bfi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_last,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);
    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_MEM   = 7'b0010000,
        S_CHK   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (i_last) n_state = i_sts.m_zero ? S_DONE : S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load_div = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_MEM;
            end
            S_MEM: begin
                o_cmd.mem_op = 1'b1;
                if (i_sts.is_query) begin
                    n_state = S_CHK;
                end else if (i_sts.probe_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.next_probe = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                if (i_sts.probe_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.next_probe = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> r_state == S_IDLE)
        else $error("finish not followed by idle");
    a_empty_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_last && i_sts.m_zero) |=> r_state == S_DONE)
        else $error("empty filter key did not finish at once");
    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_sts.div_done) |=> r_state == S_DIV)
        else $error("remainder left early");
endmodule

>>> design/bfi_dp.sv
// Datapath: configuration, FNV-1a hash, probe step, serial remainder and bit store.
module bfi_dp
    import bfi_pkg::*;
#(
    parameter int MAX_FILTER_BITS = 65536,
    parameter int MAX_PROBES      = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BITS_W-1:0]    i_cfg_data,
    input  logic                 i_mode,
    input  logic [7:0]           i_key_byte,
    input  logic                 i_has_byte,
    input  logic                 i_last,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic                 o_result_valid,
    output logic                 o_was_query,
    output logic                 o_may_contain
);
    localparam int AW = $clog2(MAX_FILTER_BITS);
    localparam int MW = $clog2(MAX_FILTER_BITS + 1);
    localparam int CW = (MW > BITS_W) ? MW : BITS_W;
    localparam int PW = $clog2(MAX_PROBES + 1);

    logic [BITS_W-1:0]   r_bit_count;
    logic [PROBES_W-1:0] r_probe_count;
    logic [63:0]         r_hash, r_sum;
    logic [31:0]         r_step;
    logic [MW-1:0]       r_rem;
    logic [5:0]          r_dcnt;
    logic [PW-1:0]       r_probe;
    logic [AW-1:0]       r_clr;
    logic                r_query, r_all, r_out_vld, r_out_q, r_out_hit;

    logic [CW-1:0]       bc_ext;
    logic [MW-1:0]       eff_m;
    logic [6:0]          pc_ext, eff_k;
    logic [MW:0]         rem_sh;
    logic [MW-1:0]       n_rem;
    logic                ram_we, ram_wd, ram_rd;
    logic [AW-1:0]       ram_wa;

    assign bc_ext = CW'(r_bit_count);
    assign eff_m  = (bc_ext > CW'(MAX_FILTER_BITS)) ? MW'(MAX_FILTER_BITS) : MW'(bc_ext);
    assign pc_ext = {1'b0, r_probe_count};
    assign eff_k  = (pc_ext == 7'd0) ? 7'd1 :
                    (pc_ext > 7'(MAX_PROBES)) ? 7'(MAX_PROBES) : pc_ext;

    // Restoring remainder, one dividend bit a cycle from the top.
    assign rem_sh = {r_rem, r_sum[63]};
    assign n_rem  = (rem_sh >= {1'b0, eff_m}) ? MW'(rem_sh - {1'b0, eff_m}) : MW'(rem_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count   <= '0;
            r_probe_count <= PROBES_W'(1);
            r_hash        <= FNV_BASIS;
            r_clr         <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_BIT_COUNT:   r_bit_count   <= i_cfg_data;
                    REG_PROBE_COUNT: r_probe_count <= i_cfg_data[PROBES_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clr_wr) r_clr <= r_clr + AW'(1);
            if (i_cmd.accept && i_has_byte) begin
                r_hash <= fnv_step(r_hash, i_key_byte);
            end else if (i_cmd.finish) begin
                r_hash <= FNV_BASIS;
            end
            r_out_vld <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_last) begin
            r_query <= i_mode;
            r_all   <= 1'b1;
            r_step  <= '0;
            r_probe <= '0;
        end
        if (i_cmd.load_div) begin
            r_sum  <= r_hash + {32'd0, r_step};
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= n_rem;
            r_sum  <= {r_sum[62:0], 1'b0};
            r_dcnt <= r_dcnt + 6'd1;
        end
        if (i_cmd.chk && !ram_rd) r_all <= 1'b0;
        if (i_cmd.next_probe) begin
            // Delta is the low word of (hash >> 17) | (hash << 15).
            r_step  <= r_step + (r_hash[48:17] | {r_hash[16:0], 15'd0});
            r_probe <= r_probe + PW'(1);
        end
        if (i_cmd.finish) begin
            r_out_q   <= r_query;
            r_out_hit <= r_query ? r_all : 1'b1;
        end
    end

    assign ram_we = i_cmd.clr_wr || (i_cmd.mem_op && !r_query);
    assign ram_wa = i_cmd.clr_wr ? r_clr : r_rem[AW-1:0];
    assign ram_wd = !i_cmd.clr_wr;

    bfi_ram #(.WIDTH(1), .DEPTH(MAX_FILTER_BITS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_wa),
        .i_wdata(ram_wd),
        .i_raddr(r_rem[AW-1:0]),
        .o_rdata(ram_rd)
    );

    assign o_sts.clr_done   = (r_clr == AW'(MAX_FILTER_BITS - 1));
    assign o_sts.m_zero     = (eff_m == '0);
    assign o_sts.div_done   = (r_dcnt == 6'd63);
    assign o_sts.probe_last = ((7'(r_probe) + 7'd1) == eff_k);
    assign o_sts.is_query   = r_query;

    assign o_result_valid = r_out_vld;
    assign o_was_query    = r_out_q;
    assign o_may_contain  = r_out_hit;
endmodule
